// ----- hdl/mbe_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants for the escape-time block.
// ----------------------------------------------------------------------------
package mbe_pkg;

    localparam int COORD_W   = 32;              // coordinate width, Q4.28
    localparam int FRAC_BITS = 28;              // fraction bits of coordinates
    localparam int ITER_W    = 16;              // iteration counter width
    localparam int SHADE_W   = 8;               // grey level width

    localparam int ZW = COORD_W + 2;            // z register width, holds z*z + c
    localparam int MW = FRAC_BITS + 3;          // multiplier operand, |z| <= 2
    localparam int PW = 2 * MW;                 // product width
    localparam int DW = ITER_W + SHADE_W + 1;   // divider remainder width

    localparam logic [ITER_W-1:0]  MAX_ITER_RST = ITER_W'(256);
    localparam logic [SHADE_W-1:0] SHADE_FULL   = {SHADE_W{1'b1}};

    typedef struct packed {
        logic signed [COORD_W-1:0] c_real;
        logic signed [COORD_W-1:0] c_imag;
    } t_in_word;

    typedef struct packed {
        logic [ITER_W-1:0]  iteration_count;
        logic [SHADE_W-1:0] shade;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DELIVER
    } t_state;

    typedef struct packed {
        logic load;     // take c, set z = c, clear count
        logic square;   // register the three products
        logic update;   // z = z*z + c, count + 1
    } t_core_ctrl;

    typedef struct packed {
        logic              stop;    // limit reached or |z| component > 2
        logic              escape;  // |z|^2 > 4 from registered products
        logic [ITER_W-1:0] count;
    } t_core_stat;

    typedef struct packed {
        logic               done;   // one-cycle pulse, shade valid from then on
        logic [SHADE_W-1:0] shade;
    } t_div_stat;

endpackage
`default_nettype wire

// ----- hdl/mbe_iter_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mbe_iter_core
// z register pair and three multipliers; each iteration: test, then update.
// ----------------------------------------------------------------------------
module mbe_iter_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire mbe_pkg::t_core_ctrl   i_ctrl,
    input  wire mbe_pkg::t_in_word     i_c,
    input  wire logic [mbe_pkg::ITER_W-1:0] i_limit,
    output mbe_pkg::t_core_stat        o_stat
);
    import mbe_pkg::*;

    localparam logic signed [ZW-1:0] TWO     = ZW'(1) << (FRAC_BITS + 1);
    localparam logic signed [ZW-1:0] NEG_TWO = -TWO;
    localparam logic signed [PW-1:0] FOUR_SQ = PW'(1) << (2 * FRAC_BITS + 2);

    logic signed [ZW-1:0]      r_zx, r_zy;
    logic signed [COORD_W-1:0] r_cx, r_cy;
    logic signed [PW-1:0]      r_xx, r_yy, r_xy;
    logic [ITER_W-1:0]         r_count;

    logic signed [MW-1:0] zx_m, zy_m;
    logic signed [PW-1:0] n_xx, n_yy, n_xy;
    logic signed [PW-1:0] sum, diff, diff_sh;
    logic signed [PW:0]   xy2, xy2_sh;
    logic signed [ZW-1:0] n_zx, n_zy;
    logic                 big;

    // operands fit MW bits whenever the magnitude test passes
    assign zx_m = r_zx[MW-1:0];
    assign zy_m = r_zy[MW-1:0];
    assign n_xx = zx_m * zx_m;
    assign n_yy = zy_m * zy_m;
    assign n_xy = zx_m * zy_m;

    assign big = (r_zx > TWO) || (r_zx < NEG_TWO) || (r_zy > TWO) || (r_zy < NEG_TWO);

    assign sum     = r_xx + r_yy;
    assign diff    = r_xx - r_yy;
    assign diff_sh = diff >>> FRAC_BITS;
    assign xy2     = {r_xy, 1'b0};
    assign xy2_sh  = xy2 >>> FRAC_BITS;
    assign n_zx    = diff_sh[ZW-1:0] + ZW'(r_cx);
    assign n_zy    = xy2_sh[ZW-1:0] + ZW'(r_cy);

    assign o_stat.stop   = (r_count >= i_limit) || big;
    assign o_stat.escape = sum > FOUR_SQ;
    assign o_stat.count  = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctrl.load) begin
            r_count <= '0;
        end else if (i_ctrl.update) begin
            r_count <= r_count + ITER_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cx <= i_c.c_real;
            r_cy <= i_c.c_imag;
            r_zx <= ZW'(i_c.c_real);
            r_zy <= ZW'(i_c.c_imag);
        end else if (i_ctrl.update) begin
            r_zx <= n_zx;
            r_zy <= n_zy;
        end
        if (i_ctrl.square) begin
            r_xx <= n_xx;
            r_yy <= n_yy;
            r_xy <= n_xy;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/mbe_shade_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mbe_shade_div
// Restoring divider, one quotient bit a cycle: 255 - ceil(255*count/limit).
// ----------------------------------------------------------------------------
module mbe_shade_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [mbe_pkg::ITER_W-1:0] i_count,
    input  wire logic [mbe_pkg::ITER_W-1:0] i_limit,
    output mbe_pkg::t_div_stat              o_stat
);
    import mbe_pkg::*;

    localparam int SW = $clog2(SHADE_W);

    logic              r_busy, r_done, r_zero;
    logic [SW-1:0]     r_step;
    logic [DW-1:0]     r_rem, r_dvs;
    logic [SHADE_W-1:0] r_q;

    logic [DW-1:0] dividend, trial;
    logic          fits;

    // 255*count + limit - 1, rounds the quotient up
    assign dividend = ((DW'(i_count) << SHADE_W) - DW'(i_count))
                      + DW'(i_limit) - DW'(1);
    assign trial = r_rem - r_dvs;
    assign fits  = r_rem >= r_dvs;

    assign o_stat.done  = r_done;
    assign o_stat.shade = r_zero ? SHADE_FULL : SHADE_FULL - r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_step == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_step == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= dividend;
            r_dvs  <= DW'(i_limit) << (SHADE_W - 1);
            r_step <= SW'(SHADE_W - 1);
            r_zero <= (i_limit == '0);
            r_q    <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= trial;
            end
            r_q    <= {r_q[SHADE_W-2:0], fits};
            r_dvs  <= r_dvs >> 1;
            r_step <= r_step - SW'(1);
        end
    end

endmodule
`default_nettype wire

// ----- hdl/mandelbrot_escape_time.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time iteration of z = z*z + c for one point, with grey shade.
// ----------------------------------------------------------------------------
// One point at a time. Each accepted word runs iterations of z = z*z + c from
// z = c, each as a test step and an update step: the test step checks the
// limit and the components of z and registers zx^2, zy^2 and zx*zy from the
// squaring multipliers, the update step tests |z|^2 > 4 and updates z. The
// iteration loop and then the shade divider run between acceptance and the
// result word. The input stalls from acceptance until the result is in the
// output register; a result waiting there does not stop the next word being
// taken.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input words
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire mbe_pkg::t_in_word           i_in_word,
    // result words
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output mbe_pkg::t_out_word               o_out_word,
    // max_iterations register
    input  wire logic                        i_cfg_we,
    input  wire logic [mbe_pkg::ITER_W-1:0]  i_cfg_wdata
);
    import mbe_pkg::*;

    t_state            r_state, n_state;
    logic [ITER_W-1:0] r_max_iter;
    logic              r_out_valid;
    t_out_word         r_out_word;

    t_core_ctrl core_ctrl;
    t_core_stat core_stat;
    t_div_stat  div_stat;
    logic       div_start;
    logic       out_load;

    // limit register; written only between points by the user, not enforced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= MAX_ITER_RST;
        end else if (i_cfg_we) begin
            r_max_iter <= i_cfg_wdata;
        end
    end

    mbe_iter_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (core_ctrl),
        .i_c     (i_in_word),
        .i_limit (r_max_iter),
        .o_stat  (core_stat)
    );

    // count is stable from the start pulse onwards
    mbe_shade_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_count (core_stat.count),
        .i_limit (r_max_iter),
        .o_stat  (div_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        core_ctrl = '0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    core_ctrl.load = 1'b1;
                    n_state        = ST_TEST;
                end
            end
            ST_TEST: begin
                // limit reached, or a component already past 2
                if (core_stat.stop) begin
                    div_start = 1'b1;
                    n_state   = ST_DIVIDE;
                end else begin
                    core_ctrl.square = 1'b1;
                    n_state          = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (core_stat.escape) begin
                    div_start = 1'b1;
                    n_state   = ST_DIVIDE;
                end else begin
                    core_ctrl.update = 1'b1;
                    n_state          = ST_TEST;
                end
            end
            ST_DIVIDE: begin
                if (div_stat.done) begin
                    n_state = ST_DELIVER;
                end
            end
            ST_DELIVER: begin
                // slot free, or its word leaves at this edge
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_word.iteration_count <= core_stat.count;
            r_out_word.shade           <= div_stat.shade;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
`default_nettype wire
